// File: rtl/core/hfm_pkg.sv
// Shared constants and a helper function for the half-precision multiplier.
package hfm_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned ProdW = 22;
  localparam logic [6:0] Bias  = 7'd15;

  // Count of leading zeros in product bits 21..10; zero when none is set.
  function automatic logic [3:0] lead_shift(input logic [ProdW-1:0] p);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i <= 11; i++) begin
      if (p[10 + i]) begin
        k = 4'(11 - i);
      end
    end
    return k;
  endfunction

endpackage

// File: rtl/core/hfm_datapath.sv
// Combinational binary16 multiply: significand product, normalize, round.
module hfm_datapath (
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output logic [15:0] product
);
  import hfm_pkg::*;

  logic        sign;
  logic [4:0]  ea, eb;
  logic [9:0]  ma, mb;
  logic [10:0] sa, sb;
  logic [ProdW-1:0] prod;
  logic [3:0]  sh;
  logic signed [7:0] expo, expo_n, dshift;
  logic [ProdW-1:0] aligned;
  logic [ProdW-1:0] norm;
  logic [13:0] rnd_in;
  logic [11:0] rnd;
  logic        zero_in, to_zero, to_max;
  logic [4:0]  expo_out;
  logic [9:0]  mant_out;
  logic [4:0]  dsh_amt;
  logic [4:0]  lsh_amt;

  always_comb begin
    sign = operand_a[15] ^ operand_b[15];
    ea = operand_a[14:10];
    eb = operand_b[14:10];
    ma = operand_a[9:0];
    mb = operand_b[9:0];
    zero_in = (ea == 5'd0 && ma == 10'd0) || (eb == 5'd0 && mb == 10'd0) ||
              (ea == 5'd0 && eb == 5'd0);
    sa = {(ea != 5'd0), ma};
    sb = {(eb != 5'd0), mb};
    prod = sa * sb;
    sh = lead_shift(prod);
    expo = 8'(ea) + 8'(eb) - 8'(Bias) - 8'(sh) +
           ((ea == 5'd0 || eb == 5'd0) ? 8'sd1 : 8'sd0);
    dshift = 8'sd0;
    if (expo >= 0) begin
      expo_n = expo + 8'sd1;
    end else begin
      expo_n = expo;
      dshift = -expo - 8'(sh);
    end
    to_max = 1'b0;
    to_zero = zero_in;
    norm = '0;
    dsh_amt = '0;
    lsh_amt = '0;
    aligned = '0;
    if (expo_n >= 8'sd32) begin
      to_max = 1'b1;
    end else if (expo_n >= 8'sd1) begin
      norm = prod << sh;
    end else if (expo_n >= -8'sd13) begin
      // denormal: shift right with sticky, or left when the lead is low
      if (dshift >= 0) begin
        dsh_amt = dshift[4:0];
        aligned = (prod >> dsh_amt) |
                  ProdW'(|(prod & ((ProdW'(1) << dsh_amt) - ProdW'(1))));
      end else begin
        lsh_amt = 5'(-dshift);
        aligned = prod << lsh_amt;
      end
      norm = aligned;
      expo_n = 8'sd0;
    end else begin
      to_zero = 1'b1;
    end
    rnd_in = {norm[21:9], norm[8] | (|norm[7:0])};
    rnd = {1'b0, rnd_in[13:3]};
    if (rnd_in[2] && (rnd_in[1] || rnd_in[0] || rnd_in[3])) begin
      rnd = rnd + 12'd1;
    end
    expo_out = expo_n[4:0];
    mant_out = rnd[9:0];
    if (rnd[11] && expo_n == 8'sd31) begin
      to_max = 1'b1;
    end else if (rnd[11]) begin
      expo_out = 5'(expo_n + 8'sd1);
      mant_out = rnd[10:1];
    end else if (rnd[10] && expo_n == 8'sd0) begin
      expo_out = 5'd1;
    end
    if (to_max) begin
      product = {sign, 15'h7FFF};
    end else if (to_zero) begin
      product = {sign, 15'd0};
    end else begin
      product = {sign, expo_out, mant_out};
    end
  end

endmodule

// File: rtl/core/half_float_multiplier.sv
// Top level: registered binary16 multiplier with stream handshakes.
//
// channel  dir  tdata
// s_axis   in   [15:0] operand_a, [31:16] operand_b
// m_axis   out  [15:0] product
//
// One request per cycle without m_axis stalls; an input and a result register.
// The single combinational multiply/normalize/round path sets the clock.
// rst clears both valid flags. A stall on m_axis holds the result and
// backs up the input register only when both stages are full.
module half_float_multiplier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // product
);
  import hfm_pkg::*;

  logic        in_valid;
  logic [31:0] in_data;
  logic [15:0] prod_c;
  logic        out_ready;

  hfm_datapath u_dp (
    .operand_a(in_data[15:0]),
    .operand_b(in_data[31:16]),
    .product  (prod_c)
  );

  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_ready) begin
        m_axis_tvalid <= in_valid;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
    if (out_ready && in_valid) begin
      m_axis_tdata <= prod_c;
    end
  end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the half-precision multiplier: directed and random requests.
`timescale 1ns / 100ps

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // operand_a, operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // product

  logic [15:0] expected_products[$];
  int          error_count = 0;
  bit          sink_hold = 1'b0;
  bit          calm = 1'b0;

  half_float_multiplier i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [21:0] sticky_rshift(logic [21:0] v, int n);
    logic [21:0] mask;
    mask = (n == 0) ? 22'd0 : ((22'd1 << n) - 22'd1);
    return (v >> n) | 22'((v & mask) != 0);
  endfunction

  function automatic logic [15:0] half_product(logic [15:0] a, logic [15:0] b);
    logic        sgn, to_zero, to_max, lsb, g, r, s;
    int          ea, eb, sh, expo, dshift;
    logic [10:0] sa, sb;
    logic [21:0] p;
    logic [11:0] rounded;
    sgn = a[15] ^ b[15];
    ea = a[14:10];
    eb = b[14:10];
    to_zero = (ea == 0 && a[9:0] == 0) || (eb == 0 && b[9:0] == 0) || (ea == 0 && eb == 0);
    to_max = 1'b0;
    dshift = 0;
    sa = (ea == 0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
    sb = (eb == 0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
    p = sa * sb;
    sh = 0;
    for (int k = 11; k >= 0; k--)
      if (p[21-k]) sh = k;
    expo = ea + eb - 15 - sh + ((ea == 0 || eb == 0) ? 1 : 0);
    if (expo >= 0) expo = expo + 1;
    else dshift = -expo - sh;
    if (expo >= 32) begin
      to_max = 1'b1;
    end else if (expo >= 1) begin
      p = sticky_rshift(p << sh, 8);
    end else if (expo >= -13) begin
      if (dshift >= 0) p = sticky_rshift(p, dshift);
      else p = p << (-dshift);
      p = sticky_rshift(p, 8);
      expo = 0;
    end else begin
      to_zero = 1'b1;
    end
    lsb = p[3];
    g = p[2];
    r = p[1];
    s = p[0];
    rounded = 12'(p >> 3);
    if (g && (r || s || lsb)) rounded = rounded + 12'd1;
    if (rounded[11] && expo == 31) begin
      to_max = 1'b1;
    end else if (rounded[11]) begin
      expo = expo + 1;
      rounded = rounded >> 1;
    end else if (rounded[10] && expo == 0) begin
      expo = 1;
    end
    if (to_max) return {sgn, 15'h7FFF};
    if (to_zero) return {sgn, 15'h0};
    return {sgn, 5'(expo), rounded[9:0]};
  endfunction

  // tvalid stays high between back-to-back requests; it drops only while idling
  task automatic send_operands(logic [15:0] a, logic [15:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    expected_products.push_back(half_product(a, b));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // result sink with random backpressure (off when calm); sink_hold holds tready low
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_products.size() == 0) begin
          $error("unexpected product %h", m_axis_tdata);
          error_count++;
        end else begin
          if (m_axis_tdata !== expected_products[0]) begin
            $error("product: expected %h actual %h", expected_products[0], m_axis_tdata);
            error_count++;
          end
          void'(expected_products.pop_front());
        end
      end
      m_axis_tready <= !sink_hold && (calm || $urandom_range(99) >= 22);
    end
  end

  task automatic test_directed();
    logic [15:0] vals[14] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h3C00,
                              16'hBC00, 16'h7BFF, 16'h7C00, 16'h7FFF, 16'hFFFF, 16'h3555,
                              16'h0200, 16'h1000};
    for (int i = 0; i < 14; i++) send_operands(vals[i], vals[13-i]);
    send_operands(16'h7BFF, 16'h7BFF);   // overflow
    send_operands(16'h0400, 16'h0400);   // underflow
    send_operands(16'h0200, 16'h0300);   // two denormals
    send_operands(16'h3BFF, 16'h3C01);   // rounds down to 1.0
    send_operands(16'h0400, 16'h37FF);   // rounds up within the denormal range
    send_operands(16'h7C00, 16'h4000);   // exponent 31 treated as ordinary
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return {1'($urandom), 5'd0, 10'($urandom)};
      2: return {1'($urandom), 5'($urandom_range(31, 26)), 10'($urandom)};
      3: return {1'($urandom), 5'($urandom_range(5, 1)), 10'($urandom)};
      default: return {1'($urandom), 5'($urandom_range(22, 9)), 10'($urandom)};
    endcase
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_operands(pick_operand(), pick_operand());
  endtask

  task automatic test_back_pressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (40) @(posedge clk);
        sink_hold = 1'b0;
      end
      test_random(30);
    join
  endtask

  task automatic test_streaming();
    calm = 1'b1;
    test_random(300);
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_back_pressure();
    test_streaming();
    test_random(700);
    s_axis_tvalid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hfm_pkg.sv
rtl/core/hfm_datapath.sv
rtl/core/half_float_multiplier.sv
bench/tb.sv
